/* hdl/rti_pkg.sv */
package rti_pkg;

  localparam int NUM_TRIANGLES   = 1024;
  localparam int COORD_FRAC_BITS = 16;

  localparam int TRI_W = 10;
  localparam int IDX_W = (NUM_TRIANGLES > 1) ? $clog2(NUM_TRIANGLES) : 1;
  localparam int CW    = 32;
  localparam int PW    = 2 * CW;
  localparam int SW    = PW - COORD_FRAC_BITS;
  localparam int SUMW  = SW + 2;
  localparam int MAGW  = SUMW - 1;
  localparam int DIVN  = CW;

  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = DIVN + 1;
  localparam int LAT       = 1 + FRONT_LAT + DIV_LAT + 1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TEST  = 1'b1;

  localparam logic [1:0] VSEL_A = 2'd0;
  localparam logic [1:0] VSEL_B = 2'd1;
  localparam logic [1:0] VSEL_C = 2'd2;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [SW-1:0]   shp_t;
  typedef logic signed [SUMW-1:0] sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    logic   valid;
    logic   ok;
    coord_t t_lo;
    coord_t t_hi;
  } meta_t;

  localparam prod_t CMAX = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam prod_t CMIN = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic coord_t sat_c(input prod_t x);
    coord_t r;
    if (x > CMAX) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (x < CMIN) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  function automatic prod_t mul(input coord_t a, input coord_t b);
    prod_t pa;
    prod_t pb;
    pa = prod_t'(a);
    pb = prod_t'(b);
    return pa * pb;
  endfunction

  // floor shift of a product back to the coordinate scale
  function automatic shp_t fsh(input prod_t p);
    prod_t s;
    s = p >>> COORD_FRAC_BITS;
    return s[SW-1:0];
  endfunction

endpackage

/* hdl/rti_store.sv */
module rti_store (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [1:0]               wsel_i,
  input  logic [rti_pkg::IDX_W-1:0] addr_i,
  input  rti_pkg::vec3_t           wdata_i,
  output rti_pkg::vec3_t           va_o,
  output rti_pkg::vec3_t           vb_o,
  output rti_pkg::vec3_t           vc_o
);
  import rti_pkg::*;

  vec3_t mem_a [NUM_TRIANGLES];
  vec3_t mem_b [NUM_TRIANGLES];
  vec3_t mem_c [NUM_TRIANGLES];

  always_ff @(posedge clk_i) begin
    if (we_i && wsel_i == VSEL_A) begin
      mem_a[addr_i] <= wdata_i;
    end
    va_o <= mem_a[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wsel_i == VSEL_B) begin
      mem_b[addr_i] <= wdata_i;
    end
    vb_o <= mem_b[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wsel_i == VSEL_C) begin
      mem_c[addr_i] <= wdata_i;
    end
    vc_o <= mem_c[addr_i];
  end

endmodule

/* hdl/rti_front.sv */
module rti_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rti_pkg::meta_t  meta_i,
  input  rti_pkg::vec3_t  va_i,
  input  rti_pkg::vec3_t  vb_i,
  input  rti_pkg::vec3_t  vc_i,
  input  rti_pkg::vec3_t  org_i,
  input  rti_pkg::vec3_t  dir_i,
  output rti_pkg::meta_t  meta_o,
  output rti_pkg::sum_t   den_o,
  output rti_pkg::sum_t   num_t_o,
  output rti_pkg::sum_t   num_u_o,
  output rti_pkg::sum_t   num_v_o
);
  import rti_pkg::*;

  meta_t meta2_q, meta3_q, meta4_q, meta5_q;
  vec3_t e1_2_q, e2_2_q, tv_2_q, d_2_q;
  vec3_t e1_3_q, e2_3_q, tv_3_q, d_3_q;
  vec3_t e1_4_q, e2_4_q, tv_4_q, d_4_q;
  vec3_t p_q, q_q;
  prod_t m3_q [12];
  prod_t m5_q [12];
  vec3_t e1_d, e2_d, tv_d, p_d, q_d;

  always_comb begin
    e1_d.x = sat_c(prod_t'(vb_i.x) - prod_t'(va_i.x));
    e1_d.y = sat_c(prod_t'(vb_i.y) - prod_t'(va_i.y));
    e1_d.z = sat_c(prod_t'(vb_i.z) - prod_t'(va_i.z));
    e2_d.x = sat_c(prod_t'(vc_i.x) - prod_t'(va_i.x));
    e2_d.y = sat_c(prod_t'(vc_i.y) - prod_t'(va_i.y));
    e2_d.z = sat_c(prod_t'(vc_i.z) - prod_t'(va_i.z));
    tv_d.x = sat_c(prod_t'(org_i.x) - prod_t'(va_i.x));
    tv_d.y = sat_c(prod_t'(org_i.y) - prod_t'(va_i.y));
    tv_d.z = sat_c(prod_t'(org_i.z) - prod_t'(va_i.z));
  end

  // P = D x E2, Q = T x E1
  always_comb begin
    p_d.x = sat_c(prod_t'(fsh(m3_q[0]))  - prod_t'(fsh(m3_q[1])));
    p_d.y = sat_c(prod_t'(fsh(m3_q[2]))  - prod_t'(fsh(m3_q[3])));
    p_d.z = sat_c(prod_t'(fsh(m3_q[4]))  - prod_t'(fsh(m3_q[5])));
    q_d.x = sat_c(prod_t'(fsh(m3_q[6]))  - prod_t'(fsh(m3_q[7])));
    q_d.y = sat_c(prod_t'(fsh(m3_q[8]))  - prod_t'(fsh(m3_q[9])));
    q_d.z = sat_c(prod_t'(fsh(m3_q[10])) - prod_t'(fsh(m3_q[11])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta2_q <= '0;
      meta3_q <= '0;
      meta4_q <= '0;
      meta5_q <= '0;
      meta_o  <= '0;
    end else begin
      meta2_q <= meta_i;
      meta3_q <= meta2_q;
      meta4_q <= meta3_q;
      meta5_q <= meta4_q;
      meta_o  <= meta5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_2_q <= e1_d;
    e2_2_q <= e2_d;
    tv_2_q <= tv_d;
    d_2_q  <= dir_i;

    m3_q[0]  <= mul(d_2_q.y, e2_2_q.z);
    m3_q[1]  <= mul(d_2_q.z, e2_2_q.y);
    m3_q[2]  <= mul(d_2_q.z, e2_2_q.x);
    m3_q[3]  <= mul(d_2_q.x, e2_2_q.z);
    m3_q[4]  <= mul(d_2_q.x, e2_2_q.y);
    m3_q[5]  <= mul(d_2_q.y, e2_2_q.x);
    m3_q[6]  <= mul(tv_2_q.y, e1_2_q.z);
    m3_q[7]  <= mul(tv_2_q.z, e1_2_q.y);
    m3_q[8]  <= mul(tv_2_q.z, e1_2_q.x);
    m3_q[9]  <= mul(tv_2_q.x, e1_2_q.z);
    m3_q[10] <= mul(tv_2_q.x, e1_2_q.y);
    m3_q[11] <= mul(tv_2_q.y, e1_2_q.x);
    e1_3_q <= e1_2_q;
    e2_3_q <= e2_2_q;
    tv_3_q <= tv_2_q;
    d_3_q  <= d_2_q;

    p_q    <= p_d;
    q_q    <= q_d;
    e1_4_q <= e1_3_q;
    e2_4_q <= e2_3_q;
    tv_4_q <= tv_3_q;
    d_4_q  <= d_3_q;

    m5_q[0]  <= mul(p_q.x, e1_4_q.x);
    m5_q[1]  <= mul(p_q.y, e1_4_q.y);
    m5_q[2]  <= mul(p_q.z, e1_4_q.z);
    m5_q[3]  <= mul(q_q.x, e2_4_q.x);
    m5_q[4]  <= mul(q_q.y, e2_4_q.y);
    m5_q[5]  <= mul(q_q.z, e2_4_q.z);
    m5_q[6]  <= mul(p_q.x, tv_4_q.x);
    m5_q[7]  <= mul(p_q.y, tv_4_q.y);
    m5_q[8]  <= mul(p_q.z, tv_4_q.z);
    m5_q[9]  <= mul(q_q.x, d_4_q.x);
    m5_q[10] <= mul(q_q.y, d_4_q.y);
    m5_q[11] <= mul(q_q.z, d_4_q.z);

    den_o   <= sum_t'(fsh(m5_q[0])) + sum_t'(fsh(m5_q[1]))  + sum_t'(fsh(m5_q[2]));
    num_t_o <= sum_t'(fsh(m5_q[3])) + sum_t'(fsh(m5_q[4]))  + sum_t'(fsh(m5_q[5]));
    num_u_o <= sum_t'(fsh(m5_q[6])) + sum_t'(fsh(m5_q[7]))  + sum_t'(fsh(m5_q[8]));
    num_v_o <= sum_t'(fsh(m5_q[9])) + sum_t'(fsh(m5_q[10])) + sum_t'(fsh(m5_q[11]));
  end

endmodule

/* hdl/rti_div.sv */
module rti_div (
  input  logic            clk_i,
  input  rti_pkg::sum_t   num_i,
  input  rti_pkg::sum_t   den_i,
  output rti_pkg::coord_t quo_o
);
  import rti_pkg::*;

  typedef logic [MAGW-1:0] mag_t;

  sum_t                          an_s, ad_s;
  logic [MAGW+COORD_FRAC_BITS-1:0] nf;
  mag_t                          rem0;

  mag_t          rem_q [DIVN+1];
  logic [CW-1:0] low_q [DIVN+1];
  logic [CW-1:0] quo_q [DIVN+1];
  mag_t          ad_q  [DIVN+1];
  logic          neg_q [DIVN+1];
  logic          sat_q [DIVN+1];

  logic [MAGW:0] r2   [DIVN];
  logic          take [DIVN];

  always_comb begin
    an_s = num_i[SUMW-1] ? -num_i : num_i;
    ad_s = den_i[SUMW-1] ? -den_i : den_i;
    nf   = {an_s[MAGW-1:0], {COORD_FRAC_BITS{1'b0}}};
    rem0 = MAGW'(nf >> CW);
  end

  always_comb begin
    for (int k = 0; k < DIVN; k++) begin
      r2[k]   = {rem_q[k], low_q[k][CW-1]};
      take[k] = r2[k] >= {1'b0, ad_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem0;
    low_q[0] <= nf[CW-1:0];
    quo_q[0] <= '0;
    ad_q[0]  <= ad_s[MAGW-1:0];
    neg_q[0] <= num_i[SUMW-1] ^ den_i[SUMW-1];
    sat_q[0] <= rem0 >= ad_s[MAGW-1:0];
    for (int k = 0; k < DIVN; k++) begin
      rem_q[k+1] <= take[k] ? MAGW'(r2[k] - {1'b0, ad_q[k]}) : r2[k][MAGW-1:0];
      low_q[k+1] <= {low_q[k][CW-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][CW-2:0], take[k]};
      ad_q[k+1]  <= ad_q[k];
      neg_q[k+1] <= neg_q[k];
      sat_q[k+1] <= sat_q[k];
    end
  end

  always_comb begin
    if (sat_q[DIVN]) begin
      quo_o = neg_q[DIVN] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else if (neg_q[DIVN]) begin
      if (quo_q[DIVN] > {1'b1, {(CW-1){1'b0}}}) begin
        quo_o = {1'b1, {(CW-1){1'b0}}};
      end else begin
        quo_o = coord_t'(-quo_q[DIVN]);
      end
    end else if (quo_q[DIVN][CW-1]) begin
      quo_o = {1'b0, {(CW-1){1'b1}}};
    end else begin
      quo_o = coord_t'(quo_q[DIVN]);
    end
  end

endmodule

/* hdl/ray_triangle_intersect.sv */
// Channel  | Handshake       | Payload
// request  | start_i, busy_o | kind, tri_index, vertex_sel, pos_*, dir_*, t_lower, t_upper
// result   | done_o strobe   | hit_flag, hit_t, bary_u, bary_v
//
// One request per cycle; busy_o stays low. A test's result passes through the
// vertex read, five geometry stages, the 33-stage divider (overflow check,
// then one quotient bit per stage) and the output register.
// Vertex writes give no result. Reset clears the request metadata and the
// done and hit flags only; the vertex store is undefined until written.
// The receiver cannot stall.
module ray_triangle_intersect (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     kind_i,
  input  logic [rti_pkg::TRI_W-1:0] tri_index_i,
  input  logic [1:0]               vertex_sel_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic signed [31:0]       dir_x_i,
  input  logic signed [31:0]       dir_y_i,
  input  logic signed [31:0]       dir_z_i,
  input  logic signed [31:0]       t_lower_i,
  input  logic signed [31:0]       t_upper_i,
  output logic                     done_o,
  output logic                     hit_flag_o,
  output logic signed [31:0]       hit_t_o,
  output logic [16:0]              bary_u_o,
  output logic [16:0]              bary_v_o
);
  import rti_pkg::*;

  localparam logic signed [CW:0] UV_ONE   = (CW+1)'(1 << COORD_FRAC_BITS);
  localparam logic [17:0]        BARY_ONE = 18'(1 << COORD_FRAC_BITS);

  logic             accept, tri_ok, we;
  logic [IDX_W-1:0] addr;
  vec3_t            pos, va, vb, vc, org1_q, dir1_q;
  meta_t            meta1_q, meta6, meta_div;
  meta_t            dly_q [DIV_LAT];
  sum_t             den, num_t, num_u, num_v;
  coord_t           t_res, u_res, v_res;
  logic signed [CW:0] uv_sum;
  logic             hit;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign tri_ok = 32'(tri_index_i) < NUM_TRIANGLES;
  assign addr   = IDX_W'(tri_index_i);
  assign we     = accept && kind_i == KIND_WRITE && tri_ok &&
                  (vertex_sel_i == VSEL_A || vertex_sel_i == VSEL_B ||
                   vertex_sel_i == VSEL_C);
  assign pos    = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};

  rti_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .wsel_i  (vertex_sel_i),
    .addr_i  (addr),
    .wdata_i (pos),
    .va_o    (va),
    .vb_o    (vb),
    .vc_o    (vc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else begin
      meta1_q <= '{valid: accept && kind_i == KIND_TEST, ok: tri_ok,
                   t_lo: t_lower_i, t_hi: t_upper_i};
    end
  end

  always_ff @(posedge clk_i) begin
    org1_q       <= pos;
    dir1_q       <= '{x: dir_x_i, y: dir_y_i, z: dir_z_i};
  end

  rti_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .meta_i  (meta1_q),
    .va_i    (va),
    .vb_i    (vb),
    .vc_i    (vc),
    .org_i   (org1_q),
    .dir_i   (dir1_q),
    .meta_o  (meta6),
    .den_o   (den),
    .num_t_o (num_t),
    .num_u_o (num_u),
    .num_v_o (num_v)
  );

  rti_div u_div_t (.clk_i(clk_i), .num_i(num_t), .den_i(den), .quo_o(t_res));
  rti_div u_div_u (.clk_i(clk_i), .num_i(num_u), .den_i(den), .quo_o(u_res));
  rti_div u_div_v (.clk_i(clk_i), .num_i(num_v), .den_i(den), .quo_o(v_res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dly_q[k] <= '0;
      end
    end else begin
      dly_q[0] <= '{valid: meta6.valid, ok: meta6.ok && den != '0,
                    t_lo: meta6.t_lo, t_hi: meta6.t_hi};
      for (int k = 1; k < DIV_LAT; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign meta_div = dly_q[DIV_LAT-1];
  assign uv_sum   = (CW+1)'(u_res) + (CW+1)'(v_res);
  assign hit      = meta_div.valid && meta_div.ok &&
                    t_res >= meta_div.t_lo && t_res <= meta_div.t_hi &&
                    !u_res[CW-1] && !v_res[CW-1] && uv_sum <= UV_ONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o     <= 1'b0;
      hit_flag_o <= 1'b0;
    end else begin
      done_o     <= meta_div.valid;
      hit_flag_o <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_t_o  <= hit ? t_res : '0;
    bary_u_o <= hit ? u_res[16:0] : '0;
    bary_v_o <= hit ? v_res[16:0] : '0;
  end

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_flag_o |-> hit_t_o == '0 && bary_u_o == '0 && bary_v_o == '0)
    else $error("miss result carries nonzero payload");

  a_bary_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_flag_o |-> ({1'b0, bary_u_o} + {1'b0, bary_v_o}) <= BARY_ONE)
    else $error("barycentric weights exceed one");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && kind_i == KIND_TEST, LAT))
    else $error("result without a matching test request");

endmodule
